FILE: src/pafs_pkg.sv
// Package for the priority aging feedback scheduler.
// Holds field widths, command and status codes, register indexes and shared types.
// No dependencies.
package pafs_pkg;

    localparam int THREADS_DEF = 64;
    localparam int QUEUE_DEPTH = 2;

    localparam int CMD_W      = 2;
    localparam int TID_W      = 6;
    localparam int STATE_W    = 2;
    localparam int BASE_W     = 8;
    localparam int PRIO_W     = 10;
    localparam int QUANT_W    = 8;
    localparam int PERIOD_W   = 10;
    localparam int BOOST_W    = 5;
    localparam int STEP_W     = 5;
    localparam int DEMOTE_W   = 6;
    localparam int BUMP_W     = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    // Input command codes
    localparam logic [CMD_W-1:0] CMD_TICK     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DISPATCH = 2'd1;
    localparam logic [CMD_W-1:0] CMD_WRITE    = 2'd2;

    // Thread status codes
    localparam logic [STATE_W-1:0] ST_OTHER   = 2'd0;
    localparam logic [STATE_W-1:0] ST_READY   = 2'd1;
    localparam logic [STATE_W-1:0] ST_CURRENT = 2'd2;
    localparam logic [STATE_W-1:0] ST_RSVD    = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_AGING_PERIOD  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_BOOST     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_QUANTUM_TICKS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEMOTE_STEP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DEMOTE    = 3'd4;

    // Configuration reset values
    localparam logic [PERIOD_W-1:0] AGING_PERIOD_RST  = 10'd100;
    localparam logic [BOOST_W-1:0]  MAX_BOOST_RST     = 5'd5;
    localparam logic [QUANT_W-1:0]  QUANTUM_TICKS_RST = 8'd40;
    localparam logic [STEP_W-1:0]   DEMOTE_STEP_RST   = 5'd5;
    localparam logic [DEMOTE_W-1:0] MAX_DEMOTE_RST    = 6'd15;

    typedef enum logic [1:0] {
        OP_TICK,
        OP_DISPATCH,
        OP_WRITE,
        OP_NOP
    } op_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_DONE
    } back_state_t;

    typedef struct packed {
        logic [PERIOD_W-1:0] aging_period;
        logic [BOOST_W-1:0]  max_boost;
        logic [QUANT_W-1:0]  quantum_ticks;
        logic [STEP_W-1:0]   demote_step;
        logic [DEMOTE_W-1:0] max_demote;
    } cfg_t;

    // Classified transaction passed from front to back
    typedef struct packed {
        op_t                op;
        logic [TID_W-1:0]   tid;
        logic [STATE_W-1:0] state;
        logic [BASE_W-1:0]  base;
        logic [PRIO_W-1:0]  prio;
    } item_t;

    // One thread table entry
    typedef struct packed {
        logic [STATE_W-1:0] status;
        logic [BASE_W-1:0]  base;
        logic [PRIO_W-1:0]  prio;
        logic [QUANT_W-1:0] quantum;
    } entry_t;

endpackage

FILE: src/pafs_front.sv
// Front part of the scheduler: accepts input transactions and classifies them.
// Checks the thread id range and normalizes the written status. Uses pafs_pkg.
module pafs_front #(
    parameter int THREADS = pafs_pkg::THREADS_DEF
) (
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [pafs_pkg::CMD_W-1:0]            cmd,
    input  logic [pafs_pkg::TID_W-1:0]            thread_id,
    input  logic [pafs_pkg::STATE_W-1:0]          thread_state,
    input  logic [pafs_pkg::BASE_W-1:0]           base_prio,
    input  logic signed [pafs_pkg::PRIO_W-1:0]    prio_value,
    input  logic                                  q_full,
    output logic                                  q_push,
    output pafs_pkg::item_t                       q_item
);

    logic tid_ok;

    assign tid_ok   = (int'(thread_id) < THREADS);
    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        q_item.tid   = thread_id;
        q_item.base  = base_prio;
        q_item.prio  = prio_value;
        // reserved status code is stored as other
        q_item.state = (thread_state == pafs_pkg::ST_RSVD) ? pafs_pkg::ST_OTHER : thread_state;
        unique case (cmd)
            pafs_pkg::CMD_TICK:     q_item.op = pafs_pkg::OP_TICK;
            pafs_pkg::CMD_DISPATCH: q_item.op = tid_ok ? pafs_pkg::OP_DISPATCH : pafs_pkg::OP_NOP;
            pafs_pkg::CMD_WRITE:    q_item.op = tid_ok ? pafs_pkg::OP_WRITE : pafs_pkg::OP_NOP;
            default:                q_item.op = pafs_pkg::OP_NOP;
        endcase
    end

endmodule

FILE: src/pafs_queue.sv
// Short queue between front and back of the scheduler.
// Holds classified transactions of type pafs_pkg::item_t.
module pafs_queue #(
    parameter int DEPTH = pafs_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  pafs_pkg::item_t  push_item,
    output logic             full,
    input  logic             pop,
    output pafs_pkg::item_t  pop_item,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pafs_pkg::item_t   store_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: src/pafs_back.sv
// Back part of the scheduler: walks the thread table once per transaction,
// applies tick, dispatch or write, ages ready threads and selects the best one.
// Uses pafs_pkg; holds the thread table memory and the result register.
module pafs_back #(
    parameter int THREADS = pafs_pkg::THREADS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  pafs_pkg::cfg_t                      cfg,
    input  logic                                q_empty,
    input  pafs_pkg::item_t                     q_item,
    output logic                                q_pop,
    input  logic                                out_stall,
    output logic                                out_valid,
    output logic                                swept,
    output logic [pafs_pkg::BUMP_W-1:0]         bumped_count,
    output logic signed [pafs_pkg::PRIO_W-1:0]  current_prio,
    output logic                                best_valid,
    output logic [pafs_pkg::TID_W-1:0]          best_tid,
    output logic signed [pafs_pkg::PRIO_W-1:0]  best_prio
);

    localparam int IDX_W = $clog2(THREADS);
    localparam int CNT_W = $clog2(THREADS + 1);
    localparam int TW    = (IDX_W > pafs_pkg::TID_W) ? IDX_W : pafs_pkg::TID_W;
    localparam int PW    = pafs_pkg::PRIO_W;

    pafs_pkg::back_state_t state_reg, state_next;
    pafs_pkg::item_t       item_reg, item_next;
    logic                  sweep_reg, sweep_next;
    logic [pafs_pkg::PERIOD_W-1:0] tc_reg, tc_next;
    logic [pafs_pkg::PERIOD_W-1:0] tc_inc;
    logic [IDX_W-1:0]      cur_reg, cur_next;
    logic [CNT_W-1:0]      scan_reg, scan_next;

    // table memory and its valid bits
    pafs_pkg::entry_t      table_mem [THREADS];
    logic [THREADS-1:0]    vld_reg;
    pafs_pkg::entry_t      rd_data_reg;
    logic                  rd_vld_reg;
    logic                  proc_reg;
    logic [IDX_W-1:0]      proc_idx_reg;
    logic                  rd_en;
    logic [IDX_W-1:0]      rd_addr;

    // running results of the walk
    logic [CNT_W-1:0]      bump_reg, bump_next;
    logic                  found_reg, found_next;
    logic [IDX_W-1:0]      btid_reg, btid_next;
    logic signed [PW-1:0]  bprio_reg, bprio_next;
    logic signed [PW-1:0]  cprio_reg, cprio_next;

    // result register
    logic                  out_valid_reg, out_valid_next;
    logic                  swept_reg;
    logic [pafs_pkg::BUMP_W-1:0] bumped_reg;
    logic signed [PW-1:0]  cur_prio_reg;
    logic                  best_valid_reg;
    logic [pafs_pkg::TID_W-1:0] best_tid_reg;
    logic signed [PW-1:0]  best_prio_reg;
    logic                  load_out;

    // entry update
    logic [TW-1:0]         tid_ext;
    logic [IDX_W-1:0]      tid_idx;
    logic                  is_cur;
    pafs_pkg::entry_t      old_e, new_e;
    logic                  bump_hit;
    logic signed [PW:0]    prio_s, base_s, demote_s, step_s, boost_s;
    logic signed [PW:0]    floor_s, ceil_s, dec_s, dem_s, inc_s;
    logic signed [PW-1:0]  new_prio_s;

    assign tid_ext  = TW'(item_reg.tid);
    assign tid_idx  = tid_ext[IDX_W-1:0];
    assign is_cur   = (proc_idx_reg == cur_reg);
    assign old_e    = rd_vld_reg ? rd_data_reg : '0;
    assign cur_next = (item_reg.op == pafs_pkg::OP_DISPATCH) ? tid_idx : cur_reg;

    assign rd_en    = (state_reg == pafs_pkg::BK_SCAN) && (scan_reg < CNT_W'(THREADS));
    assign rd_addr  = scan_reg[IDX_W-1:0];

    assign prio_s   = {old_e.prio[PW-1], old_e.prio};
    assign base_s   = {3'b000, old_e.base};
    assign demote_s = {5'b00000, cfg.max_demote};
    assign step_s   = {6'b000000, cfg.demote_step};
    assign boost_s  = {6'b000000, cfg.max_boost};
    assign floor_s  = base_s - demote_s;
    assign ceil_s   = base_s + boost_s;
    assign dec_s    = prio_s - step_s;
    assign dem_s    = (dec_s < floor_s) ? floor_s : dec_s;
    assign inc_s    = prio_s + 11'sd1;

    always_comb
    begin
        new_e    = old_e;
        bump_hit = 1'b0;
        unique case (item_reg.op)
            pafs_pkg::OP_TICK:
            begin
                // charge the running thread; the null thread is never charged
                if (is_cur && (cur_reg != '0) && (old_e.status == pafs_pkg::ST_CURRENT))
                begin
                    if (old_e.quantum > 8'd1)
                    begin
                        new_e.quantum = old_e.quantum - 8'd1;
                    end
                    else
                    begin
                        if (prio_s > floor_s)
                        begin
                            new_e.prio = dem_s[PW-1:0];
                        end
                        new_e.quantum = cfg.quantum_ticks;
                    end
                end
                if (sweep_reg && (old_e.status == pafs_pkg::ST_READY) && (prio_s < ceil_s))
                begin
                    new_e.prio = inc_s[PW-1:0];
                    bump_hit   = 1'b1;
                end
            end
            pafs_pkg::OP_DISPATCH:
            begin
                // previous current thread falls back to ready
                if (is_cur && (cur_reg != tid_idx) && (old_e.status == pafs_pkg::ST_CURRENT))
                begin
                    new_e.status = pafs_pkg::ST_READY;
                end
                if (proc_idx_reg == tid_idx)
                begin
                    new_e.status  = pafs_pkg::ST_CURRENT;
                    new_e.quantum = cfg.quantum_ticks;
                end
            end
            pafs_pkg::OP_WRITE:
            begin
                if (proc_idx_reg == tid_idx)
                begin
                    new_e.status = item_reg.state;
                    new_e.base   = item_reg.base;
                    new_e.prio   = item_reg.prio;
                end
            end
            pafs_pkg::OP_NOP:
            begin
                new_e = old_e;
            end
            default:
            begin
                new_e = old_e;
            end
        endcase
    end

    assign new_prio_s = new_e.prio;

    // sequencer: pop, walk the table, hand result to the output register
    always_comb
    begin
        state_next  = state_reg;
        item_next   = item_reg;
        sweep_next  = sweep_reg;
        tc_next     = tc_reg;
        scan_next   = scan_reg;
        bump_next   = bump_reg;
        found_next  = found_reg;
        btid_next   = btid_reg;
        bprio_next  = bprio_reg;
        cprio_next  = cprio_reg;
        q_pop       = 1'b0;
        load_out    = 1'b0;
        tc_inc      = tc_reg + 1'b1;

        if (proc_reg)
        begin
            if (bump_hit)
            begin
                bump_next = bump_reg + 1'b1;
            end
            if (proc_idx_reg == cur_next)
            begin
                cprio_next = new_prio_s;
            end
            if ((new_e.status == pafs_pkg::ST_READY) && (!found_reg || (new_prio_s > bprio_reg)))
            begin
                found_next = 1'b1;
                btid_next  = proc_idx_reg;
                bprio_next = new_prio_s;
            end
        end

        unique case (state_reg)
            pafs_pkg::BK_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    item_next  = q_item;
                    sweep_next = 1'b0;
                    if (q_item.op == pafs_pkg::OP_TICK)
                    begin
                        sweep_next = !(tc_inc < cfg.aging_period);
                        tc_next    = (tc_inc < cfg.aging_period) ? tc_inc : '0;
                    end
                    scan_next  = '0;
                    bump_next  = '0;
                    found_next = 1'b0;
                    btid_next  = '0;
                    bprio_next = '0;
                    cprio_next = '0;
                    state_next = pafs_pkg::BK_SCAN;
                end
            end
            pafs_pkg::BK_SCAN:
            begin
                if (scan_reg == CNT_W'(THREADS))
                begin
                    state_next = pafs_pkg::BK_DONE;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            pafs_pkg::BK_DONE:
            begin
                // wait until the result register is free
                if (!out_valid_reg || !out_stall)
                begin
                    load_out   = 1'b1;
                    state_next = pafs_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = pafs_pkg::BK_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg && out_stall;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    // thread table: write back the entry processed, read the next one
    always_ff @(posedge clk)
    begin
        if (proc_reg)
        begin
            table_mem[proc_idx_reg] <= new_e;
        end
        if (rd_en)
        begin
            rd_data_reg <= table_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        bump_reg  <= bump_next;
        btid_reg  <= btid_next;
        bprio_reg <= bprio_next;
        cprio_reg <= cprio_next;
        proc_idx_reg <= rd_addr;
        rd_vld_reg   <= vld_reg[rd_addr];
        if (load_out)
        begin
            swept_reg      <= sweep_reg;
            bumped_reg     <= pafs_pkg::BUMP_W'(bump_reg);
            cur_prio_reg   <= cprio_reg;
            best_valid_reg <= found_reg;
            best_tid_reg   <= pafs_pkg::TID_W'(btid_reg);
            best_prio_reg  <= bprio_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pafs_pkg::BK_IDLE;
            sweep_reg     <= 1'b0;
            tc_reg        <= '0;
            cur_reg       <= '0;
            scan_reg      <= '0;
            found_reg     <= 1'b0;
            vld_reg       <= '0;
            proc_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            tc_reg        <= tc_next;
            scan_reg      <= scan_next;
            found_reg     <= found_next;
            proc_reg      <= rd_en;
            out_valid_reg <= out_valid_next;
            if (load_out)
            begin
                cur_reg <= cur_next;
            end
            if (proc_reg)
            begin
                vld_reg[proc_idx_reg] <= 1'b1;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign swept        = swept_reg;
    assign bumped_count = bumped_reg;
    assign current_prio = cur_prio_reg;
    assign best_valid   = best_valid_reg;
    assign best_tid     = best_tid_reg;
    assign best_prio    = best_prio_reg;

endmodule

FILE: src/priority_aging_feedback_scheduler_top.sv
// Each accepted transaction gets its result after a full walk of the thread table, later if the
// output stalls. A new transaction is taken from the queue only once the previous one's single
// walk of the thread table memory (one read and one write port, one entry per cycle) is done.
// Reset: control state clears at once; table entries read as zero until first written
// through per-entry valid bits, so no clearing pass is needed.
// Top level: configuration registers, front, queue and back. Uses pafs_pkg.
module priority_aging_feedback_scheduler_top #(
    parameter int THREADS = pafs_pkg::THREADS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [pafs_pkg::CMD_W-1:0]            cmd,
    input  logic [pafs_pkg::TID_W-1:0]            thread_id,
    input  logic [pafs_pkg::STATE_W-1:0]          thread_state,
    input  logic [pafs_pkg::BASE_W-1:0]           base_prio,
    input  logic signed [pafs_pkg::PRIO_W-1:0]    prio_value,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic                                  swept,
    output logic [pafs_pkg::BUMP_W-1:0]           bumped_count,
    output logic signed [pafs_pkg::PRIO_W-1:0]    current_prio,
    output logic                                  best_valid,
    output logic [pafs_pkg::TID_W-1:0]            best_tid,
    output logic signed [pafs_pkg::PRIO_W-1:0]    best_prio,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [pafs_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [pafs_pkg::CFG_DATA_W-1:0]       cfg_data
);

    pafs_pkg::cfg_t  cfg_reg, cfg_next;
    pafs_pkg::item_t push_item;
    pafs_pkg::item_t pop_item;
    logic            q_push;
    logic            q_full;
    logic            q_pop;
    logic            q_empty;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                pafs_pkg::REG_AGING_PERIOD:  cfg_next.aging_period  = cfg_data[9:0];
                pafs_pkg::REG_MAX_BOOST:     cfg_next.max_boost     = cfg_data[4:0];
                pafs_pkg::REG_QUANTUM_TICKS: cfg_next.quantum_ticks = cfg_data[7:0];
                pafs_pkg::REG_DEMOTE_STEP:   cfg_next.demote_step   = cfg_data[4:0];
                pafs_pkg::REG_MAX_DEMOTE:    cfg_next.max_demote    = cfg_data[5:0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.aging_period  <= pafs_pkg::AGING_PERIOD_RST;
            cfg_reg.max_boost     <= pafs_pkg::MAX_BOOST_RST;
            cfg_reg.quantum_ticks <= pafs_pkg::QUANTUM_TICKS_RST;
            cfg_reg.demote_step   <= pafs_pkg::DEMOTE_STEP_RST;
            cfg_reg.max_demote    <= pafs_pkg::MAX_DEMOTE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    pafs_front #(
        .THREADS (THREADS)
    ) u_front (
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .thread_id    (thread_id),
        .thread_state (thread_state),
        .base_prio    (base_prio),
        .prio_value   (prio_value),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_item       (push_item)
    );

    pafs_queue #(
        .DEPTH (pafs_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (pop_item),
        .empty     (q_empty)
    );

    pafs_back #(
        .THREADS (THREADS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_empty      (q_empty),
        .q_item       (pop_item),
        .q_pop        (q_pop),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .swept        (swept),
        .bumped_count (bumped_count),
        .current_prio (current_prio),
        .best_valid   (best_valid),
        .best_tid     (best_tid),
        .best_prio    (best_prio)
    );

endmodule

FILE: src/pafs_checker.sv
// Port-level checks for the scheduler top level, attached with a bind.
// Depends on priority_aging_feedback_scheduler_top and pafs_pkg.
module pafs_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                out_valid,
    input logic                                out_stall,
    input logic                                swept,
    input logic [pafs_pkg::BUMP_W-1:0]         bumped_count,
    input logic signed [pafs_pkg::PRIO_W-1:0]  current_prio,
    input logic                                best_valid,
    input logic [pafs_pkg::TID_W-1:0]          best_tid,
    input logic signed [pafs_pkg::PRIO_W-1:0]  best_prio
);

    // hold a stalled result transaction
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid &&
        $stable({swept, bumped_count, current_prio, best_valid, best_tid, best_prio}))
        else $error("stalled result changed or dropped");

    a_no_sweep_no_bump: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !swept |-> bumped_count == '0)
        else $error("threads raised without a sweep");

    a_no_ready_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !best_valid |-> best_tid == '0 && best_prio == '0)
        else $error("best thread reported with no ready thread");

endmodule

bind priority_aging_feedback_scheduler_top pafs_checker u_pafs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .swept        (swept),
    .bumped_count (bumped_count),
    .current_prio (current_prio),
    .best_valid   (best_valid),
    .best_tid     (best_tid),
    .best_prio    (best_prio)
);

FILE: test/tb_priority_aging_feedback_scheduler_top.sv
`timescale 1ns / 100ps
// Testbench for priority_aging_feedback_scheduler_top: directed and random command streams,
// each result checked field by field against a scheduler model kept inside the bench.
// Depends on pafs_pkg and the scheduler RTL.
module tb_priority_aging_feedback_scheduler_top;
    import pafs_pkg::*;

    localparam int THREADS      = THREADS_DEF;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int RANDOM_ITEMS = 750;
    localparam int PHASES       = 10;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic               swept;
        logic [BUMP_W-1:0]  bumped;
        logic [PRIO_W-1:0]  cur_prio;
        logic               best_valid;
        logic [TID_W-1:0]   best_tid;
        logic [PRIO_W-1:0]  best_prio;
    } sched_result_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic [CMD_W-1:0]         cmd = '0;
    logic [TID_W-1:0]         thread_id = '0;
    logic [STATE_W-1:0]       thread_state = '0;
    logic [BASE_W-1:0]        base_prio = '0;
    logic signed [PRIO_W-1:0] prio_value = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic                     swept;
    logic [BUMP_W-1:0]        bumped_count;
    logic signed [PRIO_W-1:0] current_prio;
    logic                     best_valid;
    logic [TID_W-1:0]         best_tid;
    logic signed [PRIO_W-1:0] best_prio;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [CFG_DATA_W-1:0]    cfg_data = '0;

    // Scheduler model state and configuration
    logic [STATE_W-1:0] thr_status [THREADS];
    int thr_base [THREADS];
    int thr_prio [THREADS];
    int thr_quantum [THREADS];
    int age_count;
    int cur_thread;
    int cfg_period;
    int cfg_boost;
    int cfg_quantum;
    int cfg_step;
    int cfg_demote;

    sched_result_t predicted_q [$];
    int mismatches = 0;
    int items_sent = 0;
    int results_seen = 0;
    int sweeps_seen = 0;
    int demotions_seen = 0;
    int settings_used = 0;
    int cycle_count = 0;
    int gap_pct = 0;
    int stall_pct = 0;
    int stall_left = 0;

    priority_aging_feedback_scheduler_top #(
        .THREADS(THREADS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .cmd(cmd),
        .thread_id(thread_id),
        .thread_state(thread_state),
        .base_prio(base_prio),
        .prio_value(prio_value),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .swept(swept),
        .bumped_count(bumped_count),
        .current_prio(current_prio),
        .best_valid(best_valid),
        .best_tid(best_tid),
        .best_prio(best_prio),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #1 clk = ~clk;

    function automatic sched_result_t schedule_step(input logic [CMD_W-1:0] c,
            input logic [TID_W-1:0] tid, input logic [STATE_W-1:0] st,
            input logic [BASE_W-1:0] b, input logic signed [PRIO_W-1:0] pv);
        sched_result_t r;
        int demote_floor;
        int best;
        bit found;
        r = '0;
        found = 1'b0;
        best = 0;
        case (c)
            CMD_TICK:
            begin
                // skip the null thread and a current thread no longer marked current
                if (cur_thread != 0 && thr_status[cur_thread] == ST_CURRENT)
                begin
                    if (thr_quantum[cur_thread] > 1)
                        thr_quantum[cur_thread] = thr_quantum[cur_thread] - 1;
                    else
                    begin
                        demote_floor = thr_base[cur_thread] - cfg_demote;
                        if (thr_prio[cur_thread] > demote_floor)
                        begin
                            thr_prio[cur_thread] = thr_prio[cur_thread] - cfg_step;
                            if (thr_prio[cur_thread] < demote_floor)
                                thr_prio[cur_thread] = demote_floor;
                            demotions_seen++;
                        end
                        thr_quantum[cur_thread] = cfg_quantum;
                    end
                end
                age_count = (age_count + 1) % 1024;
                if (age_count >= cfg_period)
                begin
                    age_count = 0;
                    r.swept = 1'b1;
                    sweeps_seen++;
                    for (int i = 0; i < THREADS; i++)
                    begin
                        if (thr_status[i] == ST_READY && thr_prio[i] < thr_base[i] + cfg_boost)
                        begin
                            thr_prio[i] = thr_prio[i] + 1;
                            r.bumped = r.bumped + 1'b1;
                        end
                    end
                end
            end
            CMD_DISPATCH:
            begin
                // demote the old current thread back to ready
                if (cur_thread != int'(tid) && thr_status[cur_thread] == ST_CURRENT)
                    thr_status[cur_thread] = ST_READY;
                cur_thread = int'(tid);
                thr_status[tid] = ST_CURRENT;
                thr_quantum[tid] = cfg_quantum;
            end
            CMD_WRITE:
            begin
                thr_status[tid] = (st == ST_RSVD) ? ST_OTHER : st;
                thr_base[tid] = int'(b);
                thr_prio[tid] = int'(pv);
            end
            default:
            begin
            end
        endcase
        for (int i = 0; i < THREADS; i++)
        begin
            if (thr_status[i] == ST_READY && (!found || thr_prio[i] > best))
            begin
                found = 1'b1;
                r.best_tid = i[TID_W-1:0];
                best = thr_prio[i];
            end
        end
        r.best_valid = found;
        r.best_prio = best[PRIO_W-1:0];
        r.cur_prio = thr_prio[cur_thread][PRIO_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ERROR: result %0d: %s", $time, results_seen, msg);
        mismatches++;
    endtask

    task automatic check_result(input sched_result_t want);
        if (swept !== want.swept)
            report_mismatch($sformatf("swept got %0d expected %0d", swept, want.swept));
        if (bumped_count !== want.bumped)
            report_mismatch($sformatf("bumped_count got %0d expected %0d",
                bumped_count, want.bumped));
        if (current_prio !== want.cur_prio)
            report_mismatch($sformatf("current_prio got %0d expected %0d",
                current_prio, $signed(want.cur_prio)));
        if (best_valid !== want.best_valid)
            report_mismatch($sformatf("best_valid got %0d expected %0d",
                best_valid, want.best_valid));
        if (best_tid !== want.best_tid)
            report_mismatch($sformatf("best_tid got %0d expected %0d", best_tid, want.best_tid));
        if (best_prio !== want.best_prio)
            report_mismatch($sformatf("best_prio got %0d expected %0d",
                best_prio, $signed(want.best_prio)));
    endtask

    // Predict on input transactions, then check output transactions, in one process
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                predicted_q.push_back(schedule_step(cmd, thread_id, thread_state,
                    base_prio, prio_value));
                items_sent++;
            end
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (predicted_q.size() == 0)
                    report_mismatch("result with no transaction pending");
                else
                    check_result(predicted_q.pop_front());
            end
        end
    end

    // Output back-pressure in random bursts
    always @(negedge clk)
    begin
        if (stall_pct == 0)
        begin
            out_stall <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 99) < stall_pct)
        begin
            out_stall <= 1'b1;
            stall_left <= $urandom_range(0, 13);
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results pending",
                cycle_count, predicted_q.size());
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_item(input logic [CMD_W-1:0] c, input logic [TID_W-1:0] tid,
            input logic [STATE_W-1:0] st, input logic [BASE_W-1:0] b, input int pv);
        @(negedge clk);
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
        cmd <= c;
        thread_id <= tid;
        thread_state <= st;
        base_prio <= b;
        prio_value <= pv[PRIO_W-1:0];
        in_valid <= 1'b1;
        // hold the payload until the transaction is taken
        do @(posedge clk); while (in_stall);
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (predicted_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(negedge clk);
        cfg_index <= idx;
        cfg_data <= value[CFG_DATA_W-1:0];
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_AGING_PERIOD:  cfg_period = int'(value[PERIOD_W-1:0]);
            REG_MAX_BOOST:     cfg_boost = int'(value[BOOST_W-1:0]);
            REG_QUANTUM_TICKS: cfg_quantum = int'(value[QUANT_W-1:0]);
            REG_DEMOTE_STEP:   cfg_step = int'(value[STEP_W-1:0]);
            REG_MAX_DEMOTE:    cfg_demote = int'(value[DEMOTE_W-1:0]);
            default:
            begin
            end
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_config(input int period, input int boost, input int quantum,
            input int step, input int demote);
        wait_for_results();
        write_register(REG_AGING_PERIOD, period);
        write_register(REG_MAX_BOOST, boost);
        write_register(REG_QUANTUM_TICKS, quantum);
        write_register(REG_DEMOTE_STEP, step);
        write_register(REG_MAX_DEMOTE, demote);
        settings_used++;
    endtask

    task automatic send_random_item();
        int kind;
        int tid;
        int b;
        int pv;
        logic [STATE_W-1:0] st;
        kind = $urandom_range(0, 99);
        // keep most traffic on a small pool of threads so dispatch and aging interact
        tid = ($urandom_range(0, 3) == 0) ? $urandom_range(0, THREADS - 1) : $urandom_range(0, 7);
        b = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 40);
        pv = b + int'($urandom_range(0, 40)) - 20;
        if (pv > 511)
            pv = 511;
        case ($urandom_range(0, 9))
            0, 1:    st = ST_OTHER;
            2:       st = ST_CURRENT;
            3:       st = ST_RSVD;
            default: st = ST_READY;
        endcase
        if (kind < 55)
            send_item(CMD_TICK, TID_W'($urandom_range(0, THREADS - 1)),
                STATE_W'($urandom_range(0, 3)), BASE_W'($urandom_range(0, 255)),
                int'($urandom_range(0, 1023)) - 512);
        else if (kind < 68)
            send_item(CMD_DISPATCH, TID_W'(tid), st, BASE_W'(b), pv);
        else if (kind < 92)
            send_item(CMD_WRITE, TID_W'(tid), st, BASE_W'(b), pv);
        else if (kind < 97)
            send_item(CMD_WRITE, TID_W'($urandom_range(0, THREADS - 1)),
                STATE_W'($urandom_range(0, 3)), BASE_W'($urandom_range(0, 255)),
                int'($urandom_range(0, 1023)) - 512);
        else
            send_item(CMD_UNUSED, TID_W'($urandom_range(0, THREADS - 1)),
                STATE_W'($urandom_range(0, 3)), BASE_W'($urandom_range(0, 255)),
                int'($urandom_range(0, 1023)) - 512);
    endtask

    // Reset values and default configuration, unknown command, null thread current
    task automatic test_reset_defaults();
        send_item(CMD_UNUSED, 6'd63, ST_RSVD, 8'd255, -1);
        send_item(CMD_DISPATCH, 6'd0, ST_OTHER, 8'd0, 0);
        send_item(CMD_TICK, 6'd0, ST_OTHER, 8'd0, 0);
    endtask

    // Field extremes, tie on priority, reserved status, current set by a write
    task automatic test_table_writes();
        send_item(CMD_WRITE, 6'd63, ST_READY, 8'd255, 511);
        send_item(CMD_WRITE, 6'd2, ST_READY, 8'd0, 511);
        send_item(CMD_WRITE, 6'd1, ST_READY, 8'd0, -512);
        send_item(CMD_WRITE, 6'd4, ST_RSVD, 8'd170, -342);
        send_item(CMD_WRITE, 6'd5, ST_CURRENT, 8'd85, 341);
        send_item(CMD_TICK, 6'd42, ST_RSVD, 8'd255, -1);
    endtask

    // One-tick quantum: demote down to the floor, redispatch, status changed under the thread
    task automatic test_quantum_feedback();
        apply_config(1, 31, 1, 31, 63);
        send_item(CMD_WRITE, 6'd9, ST_READY, 8'd100, 100);
        send_item(CMD_DISPATCH, 6'd9, ST_OTHER, 8'd0, 0);
        repeat (4) send_item(CMD_TICK, 6'd0, ST_OTHER, 8'd0, 0);
        send_item(CMD_DISPATCH, 6'd9, ST_OTHER, 8'd0, 0);
        send_item(CMD_DISPATCH, 6'd63, ST_OTHER, 8'd0, 0);
        send_item(CMD_WRITE, 6'd63, ST_OTHER, 8'd255, 511);
        send_item(CMD_TICK, 6'd0, ST_OTHER, 8'd0, 0);
        send_item(CMD_DISPATCH, 6'd0, ST_OTHER, 8'd0, 0);
        send_item(CMD_TICK, 6'd0, ST_OTHER, 8'd0, 0);
    endtask

    // Long period, then a period below the running count, then a zero period
    task automatic test_period_edges();
        apply_config(1023, 0, 255, 0, 0);
        repeat (3) send_item(CMD_TICK, 6'd0, ST_OTHER, 8'd0, 0);
        apply_config(2, 0, 255, 0, 0);
        send_item(CMD_TICK, 6'd0, ST_OTHER, 8'd0, 0);
        apply_config(0, 5, 255, 0, 0);
        repeat (2) send_item(CMD_TICK, 6'd0, ST_OTHER, 8'd0, 0);
    endtask

    task automatic test_random_phases();
        int period;
        int boost;
        int quantum;
        int step;
        int demote;
        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase == PHASES - 1 || phase == 3)
            begin
                gap_pct = 0;
                stall_pct = 0;
            end
            else
            begin
                gap_pct = $urandom_range(5, 30);
                stall_pct = $urandom_range(5, 30);
            end
            if (phase == 0)
            begin
                period = 1;
                boost = 0;
                quantum = 1;
                step = 0;
                demote = 0;
            end
            else if (phase == 1)
            begin
                period = 1023;
                boost = 31;
                quantum = 255;
                step = 31;
                demote = 63;
            end
            else
            begin
                period = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 1023)
                                                     : $urandom_range(1, 12);
                boost = $urandom_range(0, 31);
                quantum = $urandom_range(1, 8);
                step = $urandom_range(0, 31);
                demote = $urandom_range(0, 63);
            end
            apply_config(period, boost, quantum, step, demote);
            for (int n = 0; n < RANDOM_ITEMS / PHASES; n++)
            begin
                // hold off until the pipeline is empty once mid-phase
                if (phase == 4 && n == 40)
                    wait_for_results();
                send_random_item();
            end
        end
    endtask

    initial
    begin
        for (int i = 0; i < THREADS; i++)
        begin
            thr_status[i] = ST_OTHER;
            thr_base[i] = 0;
            thr_prio[i] = 0;
            thr_quantum[i] = 0;
        end
        age_count = 0;
        cur_thread = 0;
        cfg_period = int'(AGING_PERIOD_RST);
        cfg_boost = int'(MAX_BOOST_RST);
        cfg_quantum = int'(QUANTUM_TICKS_RST);
        cfg_step = int'(DEMOTE_STEP_RST);
        cfg_demote = int'(MAX_DEMOTE_RST);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        gap_pct = 20;
        stall_pct = 20;
        test_reset_defaults();
        test_table_writes();
        test_quantum_feedback();
        test_period_edges();
        test_random_phases();

        wait_for_results();
        repeat (THREADS + 8) @(posedge clk);
        if (predicted_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", predicted_q.size()));
        $display("Sent %0d transactions, checked %0d results over %0d register settings.",
            items_sent, results_seen, settings_used);
        $display("Model ran %0d aging sweeps and %0d quantum expiries with demotion.",
            sweeps_seen, demotions_seen);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: priority_aging_feedback_scheduler_top.f
src/pafs_pkg.sv
src/pafs_front.sv
src/pafs_queue.sv
src/pafs_back.sv
src/priority_aging_feedback_scheduler_top.sv
src/pafs_checker.sv
test/tb_priority_aging_feedback_scheduler_top.sv
